@@ rtl/binary_to_decimal_ascii_unit_assert.svh @@
// Assertion macros shared by the RTL of the decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/b2da_pkg.sv @@
package b2da_pkg;

  // Width of one packed BCD digit.
  localparam int BCD_DIGIT_W = 4;

  // ASCII code of the character '0', at the width of the result field.
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef logic [5:0] ascii_char_t;

endpackage

@@ rtl/binary_to_decimal_ascii_unit.sv @@
// Path: a transferred number moves from stage 0 through the shift stages in order into the
// character stage, which sends its characters most significant first, one per cycle while out_tready is high.
// Throughput: the conversion pipeline takes one number per cycle unless the character stage
// is busy; that stage takes a new number only as the last character of the one before transfers.
// Reset: rst_n is synchronous and active low; it clears all valid bits, no characters.
`include "binary_to_decimal_ascii_unit_assert.svh"

module binary_to_decimal_ascii_unit
  import b2da_pkg::*;
#(
  parameter int VALUE_BITS  = 16,
  parameter int DIGIT_COUNT = 5
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: value.
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0: ascii_digit (6 bits), then two zero bits.
  output logic [7:0]                            out_tdata,
  output logic                                  out_tlast
);

  localparam int BCD_W = BCD_DIGIT_W * DIGIT_COUNT;
  localparam int PTR_W = $clog2(DIGIT_COUNT);

  // Stage 0 holds the transferred number; stage k holds it after k shift steps.
  logic [VALUE_BITS-1:0] val_r   [0:VALUE_BITS];
  logic [BCD_W-1:0]      bcd_r   [0:VALUE_BITS];
  logic [VALUE_BITS:0]   vld_r;
  logic [VALUE_BITS:0]   adv;
  logic [VALUE_BITS-1:0] val_nxt [0:VALUE_BITS-1];
  logic [BCD_W-1:0]      bcd_nxt [0:VALUE_BITS-1];

  logic                  em_valid_r;
  logic [BCD_W-1:0]      em_bcd_r;
  logic [PTR_W-1:0]      em_ptr_r;
  logic [PTR_W-1:0]      top_nxt;
  logic                  em_free;
  logic                  em_load;
  logic [BCD_DIGIT_W-1:0] em_digit;
  ascii_char_t           em_char;

  assign em_free = !em_valid_r || (out_tready && (em_ptr_r == '0));
  assign em_load = vld_r[VALUE_BITS] && em_free;

  assign adv[VALUE_BITS] = !vld_r[VALUE_BITS] || em_load;
  assign in_tready       = adv[0];

  genvar gk;
  generate
    for (gk = 0; gk < VALUE_BITS; gk++) begin : g_step
      assign adv[gk] = !vld_r[gk] || adv[gk+1];

      // One double dabble step: add 3 to every digit of five or more, then shift in a bit.
      always_comb begin
        logic [BCD_W-1:0] corr;
        corr = bcd_r[gk];
        for (int d = 0; d < DIGIT_COUNT; d++) begin
          if (bcd_r[gk][d*BCD_DIGIT_W +: BCD_DIGIT_W] >= BCD_DIGIT_W'(5)) begin
            corr[d*BCD_DIGIT_W +: BCD_DIGIT_W] =
              bcd_r[gk][d*BCD_DIGIT_W +: BCD_DIGIT_W] + BCD_DIGIT_W'(3);
          end
        end
        bcd_nxt[gk] = {corr[BCD_W-2:0], val_r[gk][VALUE_BITS-1]};
        val_nxt[gk] = {val_r[gk][VALUE_BITS-2:0], 1'b0};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[gk+1] <= 1'b0;
        end else if (adv[gk+1]) begin
          vld_r[gk+1] <= vld_r[gk];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[gk+1]) begin
          bcd_r[gk+1] <= bcd_nxt[gk];
          val_r[gk+1] <= val_nxt[gk];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv[0]) begin
      vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      val_r[0] <= in_tdata[VALUE_BITS-1:0];
      bcd_r[0] <= '0;
    end
  end

  // Most significant nonzero digit; an all-zero result starts at digit zero.
  always_comb begin
    top_nxt = '0;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      if (bcd_r[VALUE_BITS][k*BCD_DIGIT_W +: BCD_DIGIT_W] != '0) begin
        top_nxt = PTR_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
    end else if (em_load) begin
      em_valid_r <= 1'b1;
    end else if (out_tready && (em_ptr_r == '0)) begin
      em_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      em_bcd_r <= bcd_r[VALUE_BITS];
      em_ptr_r <= top_nxt;
    end else if (em_valid_r && out_tready) begin
      em_ptr_r <= em_ptr_r - PTR_W'(1);
    end
  end

  assign em_digit   = em_bcd_r[em_ptr_r*BCD_DIGIT_W +: BCD_DIGIT_W];
  assign em_char    = ASCII_ZERO + {2'b00, em_digit};
  assign out_tvalid = em_valid_r;
  assign out_tdata  = {2'b00, em_char};
  assign out_tlast  = (em_ptr_r == '0);

  `B2DA_ASSERT_NOW(a_char_is_digit, out_tvalid,
    (out_tdata[5:0] >= 6'd48) && (out_tdata[5:0] <= 6'd57),
    "character out of the decimal digit range")
  `B2DA_ASSERT_NEXT(a_input_captured, in_tvalid && in_tready, vld_r[0],
    "transferred number not captured in the first stage")
  `B2DA_ASSERT_NEXT(a_number_held, em_valid_r && !(out_tready && out_tlast), em_valid_r,
    "number dropped before its last character was transferred")
  `B2DA_ASSERT_NEXT(a_stall_holds_tail, vld_r[VALUE_BITS] && !em_free,
    vld_r[VALUE_BITS],
    "converted number lost while the character stage was busy")

endmodule

@@ verif/tb_binary_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii_unit
  import b2da_pkg::*;
();

  localparam int VALUE_BITS  = 16;
  localparam int DIGIT_COUNT = 5;
  localparam int BCD_BITS    = BCD_DIGIT_W * DIGIT_COUNT;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * (VALUE_BITS + 2 + DIGIT_COUNT);
  localparam int RANDOM_ITEMS = 140;

  typedef struct packed {
    ascii_char_t code;
    logic        last;
  } digit_char_t;

  typedef struct {
    logic [VALUE_BITS-1:0] value;
    string                 text;
  } probe_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  // Fields from bit 0: value.
  logic [15:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  // Fields from bit 0: ascii_digit (6 bits), then two zero bits.
  logic [7:0] out_tdata;
  logic       out_tlast;

  digit_char_t digit_q[$];
  digit_char_t want_char;
  int unsigned mismatch_count = 0;
  bit          steady_send = 1'b0;

  // An empty text means the row is checked against the predictor.
  probe_row_t probe_rows [20] = '{
    '{16'd0,     "0"},
    '{16'd65535, "65535"},
    '{16'd1,     "1"},
    '{16'd9,     "9"},
    '{16'd10,    "10"},
    '{16'd99,    "99"},
    '{16'd100,   "100"},
    '{16'd999,   "999"},
    '{16'd1000,  "1000"},
    '{16'd9999,  "9999"},
    '{16'd10000, "10000"},
    '{16'd12345, "12345"},
    '{16'd50000, "50000"},
    '{16'd255,   "255"},
    '{16'd10001, ""},
    '{16'h8000,  ""},
    '{16'h5555,  ""},
    '{16'hAAAA,  ""},
    '{16'd60006, ""},
    '{16'h1000,  ""}
  };

  binary_to_decimal_ascii_unit #(
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t ns: %s", $time, what);
  endtask

  // Shift-and-add-3 conversion, one value bit per step, most significant first.
  function automatic logic [BCD_BITS-1:0] to_bcd(input logic [VALUE_BITS-1:0] value);
    logic [BCD_BITS-1:0] bcd;
    bcd = '0;
    for (int step = 0; step < VALUE_BITS; step++) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        if (bcd[BCD_DIGIT_W*k +: BCD_DIGIT_W] >= 4'd5)
          bcd[BCD_DIGIT_W*k +: BCD_DIGIT_W] = bcd[BCD_DIGIT_W*k +: BCD_DIGIT_W] + 4'd3;
      end
      bcd = {bcd[BCD_BITS-2:0], value[VALUE_BITS-1-step]};
    end
    return bcd;
  endfunction

  task automatic queue_predicted_digits(input logic [VALUE_BITS-1:0] value);
    logic [BCD_BITS-1:0]    bcd;
    logic [BCD_DIGIT_W-1:0] d;
    int                     top;
    digit_char_t            ch;
    bcd = to_bcd(value);
    top = 0;
    for (int k = 0; k < DIGIT_COUNT; k++)
      if (bcd[BCD_DIGIT_W*k +: BCD_DIGIT_W] != '0) top = k;
    for (int k = top; k >= 0; k--) begin
      d       = bcd[BCD_DIGIT_W*k +: BCD_DIGIT_W];
      ch.code = ASCII_ZERO + {2'b00, d};
      ch.last = (k == 0);
      digit_q.push_back(ch);
    end
  endtask

  task automatic queue_typed_digits(input string text);
    digit_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      ch.code = ascii_char_t'(text[i]);
      ch.last = (i == text.len() - 1);
      digit_q.push_back(ch);
    end
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 10) return 0;
    if (sel < 17) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    int unsigned pow10 [5] = '{1, 10, 100, 1000, 10000};
    int unsigned sel;
    int          near;
    sel = $urandom_range(0, 9);
    if (sel < 5) return VALUE_BITS'($urandom);
    if (sel < 7) return VALUE_BITS'($urandom_range(0, 99));
    if (sel < 9) begin
      near = int'(pow10[$urandom_range(0, 4)]) + int'($urandom_range(0, 2)) - 1;
      return VALUE_BITS'(near);
    end
    return VALUE_BITS'($urandom_range(60000, 65535));
  endfunction

  // Offers one value, waits for its transfer, queues its expected characters, then may idle.
  task automatic send_value(input logic [VALUE_BITS-1:0] value, input string text);
    int unsigned gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    if (text.len() != 0) queue_typed_digits(text);
    else queue_predicted_digits(value);
    gap = steady_send ? 0 : gap_len();
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= VALUE_BITS'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (probe_rows[i]) send_value(probe_rows[i].value, probe_rows[i].text);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) steady_send = ($urandom_range(0, 3) == 0);
      // Let the unit drain completely once before refilling it.
      if (n == RANDOM_ITEMS / 2) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (digit_q.size() != 0) @(posedge clk);
      end
      send_value(pick_value(), "");
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (digit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    int unsigned g;
    out_tready = 1'b0;
    hold_left  = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
      end else if (!out_tready) begin
        out_tready <= 1'b1;
        hold_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 6);
      end else begin
        g = gap_len();
        if (g != 0) begin
          out_tready <= 1'b0;
          hold_left  = g - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digit_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h last=%b", out_tdata, out_tlast));
      end else begin
        want_char = digit_q.pop_front();
        if (out_tdata !== {2'b00, want_char.code})
          report_mismatch($sformatf("ascii_digit 0x%02h, wanted 0x%02h",
                                    out_tdata, {2'b00, want_char.code}));
        if (out_tlast !== want_char.last)
          report_mismatch($sformatf("last_digit %b, wanted %b", out_tlast, want_char.last));
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
